// ----- hdl/artt_pkg.sv -----
// ----------------------------------------------------------------------------
// artt_pkg
// Types and constants shared by the address region translation table.
// ----------------------------------------------------------------------------
package artt_pkg;

    localparam logic [2:0] MODE_LOOKUP   = 3'd0;
    localparam logic [2:0] MODE_ADD      = 3'd1;
    localparam logic [2:0] MODE_PITCH    = 3'd2;
    localparam logic [2:0] MODE_DEL_ADDR = 3'd3;
    localparam logic [2:0] MODE_DEL_BASE = 3'd4;
    localparam logic [2:0] MODE_DEL_BSZ  = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_NULL = 2'd3;

    typedef struct packed {
        logic [2:0]         mode;
        logic [63:0]        address;
        logic [63:0]        region_size;
        logic [63:0]        buffer;
        logic [1:0]         dims;
        logic signed [31:0] trace_pitch_in;
        logic signed [31:0] real_pitch_in;
    } artt_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               overlapped;
        logic [63:0]        out_pointer;
        logic [63:0]        out_length;
        logic [1:0]         out_dims;
        logic signed [31:0] out_trace_pitch;
        logic signed [31:0] out_real_pitch;
    } artt_out_t;

    // one stored region, data word of the region memory
    typedef struct packed {
        logic [63:0] start;
        logic [63:0] length;
        logic [63:0] base;
        logic [1:0]  dims;
        logic [63:0] pitches;
    } artt_entry_t;

    localparam int ENTRY_W = $bits(artt_entry_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TAIL,
        S_FETCH,
        S_WAIT,
        S_RESULT,
        S_OUT
    } artt_state_t;

    typedef struct packed {
        logic start;    // latch item, clear scan
        logic scan;     // compare entry on read data
        logic fetch;    // read chosen entry
        logic finish;   // compute result and write back
    } artt_cmd_t;

    typedef struct packed {
        logic need_fetch;
    } artt_stat_t;

endpackage

// ----- hdl/artt_ram.sv -----
// ----------------------------------------------------------------------------
// artt_ram
// Generic single port write, single port read RAM with registered read.
// ----------------------------------------------------------------------------
module artt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/artt_datapath.sv -----
// ----------------------------------------------------------------------------
// artt_datapath
// Region memory, scan registers and result formation.
// ----------------------------------------------------------------------------
module artt_datapath #(
    parameter int REGIONS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  artt_pkg::artt_cmd_t  cmd,
    output artt_pkg::artt_stat_t stat,
    input  artt_pkg::artt_in_t   in_item,
    output artt_pkg::artt_out_t  result
);

    localparam int IW = $clog2(REGIONS);

    artt_pkg::artt_in_t    item_reg;
    logic [REGIONS-1:0]    valid_reg;
    logic [IW-1:0]         raddr_reg, raddr_next;
    logic [IW-1:0]         cmp_idx_reg;
    logic                  cmp_vld_reg;
    logic                  found_reg;
    logic [IW-1:0]         best_reg;
    logic [63:0]           best_start_reg;
    logic                  same_reg;
    logic [IW-1:0]         same_idx_reg;
    logic                  free_reg;
    logic [IW-1:0]         free_idx_reg;
    logic                  ov_reg;
    artt_pkg::artt_out_t   result_reg;
    artt_pkg::artt_out_t   result_next;

    logic                  we;
    logic [IW-1:0]         waddr;
    artt_pkg::artt_entry_t wdata;
    artt_pkg::artt_entry_t rdata;
    logic [IW-1:0]         ram_raddr;

    artt_ram #(
        .WIDTH(artt_pkg::ENTRY_W),
        .DEPTH(REGIONS)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(ram_raddr),
        .rdata(rdata)
    );

    assign ram_raddr = cmd.fetch ? best_reg : raddr_reg;
    assign stat.need_fetch = (item_reg.mode == artt_pkg::MODE_LOOKUP)
                          || (item_reg.mode == artt_pkg::MODE_PITCH)
                          || (item_reg.mode == artt_pkg::MODE_DEL_ADDR);
    assign result = result_reg;

    // per entry compare on the read data
    logic [64:0] e_end, n_end;
    logic        is_valid, c_addr, c_base, c_ov;
    always_comb
    begin
        e_end    = {1'b0, rdata.start} + {1'b0, rdata.length};
        n_end    = {1'b0, item_reg.address} + {1'b0, item_reg.region_size};
        is_valid = valid_reg[cmp_idx_reg];
        c_addr   = is_valid && (rdata.start <= item_reg.address)
                && (!found_reg || rdata.start > best_start_reg);
        c_base   = is_valid && (rdata.base == item_reg.buffer)
                && (item_reg.mode != artt_pkg::MODE_DEL_BSZ
                    || rdata.length == item_reg.region_size)
                && (!found_reg || rdata.start < best_start_reg);
        c_ov     = is_valid && (rdata.start != item_reg.address)
                && (item_reg.region_size != 64'd0) && (rdata.length != 64'd0)
                && ({1'b0, rdata.start} < n_end)
                && ({1'b0, item_reg.address} < e_end);
    end

    // result formation on the fetched entry
    logic [63:0] off;
    logic        hit;
    logic [64:0] f_end;
    always_comb
    begin
        off   = item_reg.address - rdata.start;
        f_end = {1'b0, rdata.start} + {1'b0, rdata.length};
        hit   = found_reg && ({1'b0, item_reg.address} < f_end);
    end

    logic [IW-1:0] add_slot;
    logic          add_ok;
    always_comb
    begin
        add_slot = same_reg ? same_idx_reg : free_idx_reg;
        add_ok   = same_reg || free_reg;
        we       = 1'b0;
        waddr    = add_slot;
        wdata    = rdata;
        if (cmd.finish && item_reg.mode == artt_pkg::MODE_ADD
            && item_reg.address != 64'd0 && add_ok)
        begin
            we            = 1'b1;
            wdata.start   = item_reg.address;
            wdata.length  = item_reg.region_size;
            wdata.base    = item_reg.buffer;
            wdata.dims    = 2'd0;
            wdata.pitches = 64'd0;
        end
        else if (cmd.finish && item_reg.mode == artt_pkg::MODE_PITCH && hit)
        begin
            we            = 1'b1;
            waddr         = best_reg;
            wdata.dims    = item_reg.dims;
            wdata.pitches = {item_reg.real_pitch_in, item_reg.trace_pitch_in};
        end
    end

    always_comb
    begin
        result_next        = '0;
        result_next.status = artt_pkg::ST_MISS;
        unique case (item_reg.mode)
            artt_pkg::MODE_LOOKUP:
            begin
                if (hit)
                begin
                    result_next.status          = artt_pkg::ST_OK;
                    result_next.out_pointer     = rdata.base + off;
                    result_next.out_length      = rdata.length - off;
                    result_next.out_dims        = rdata.dims;
                    result_next.out_trace_pitch = rdata.pitches[31:0];
                    result_next.out_real_pitch  = rdata.pitches[63:32];
                end
                else
                begin
                    result_next.out_pointer = item_reg.address;
                end
            end
            artt_pkg::MODE_ADD:
            begin
                if (item_reg.address == 64'd0)
                begin
                    result_next.status = artt_pkg::ST_NULL;
                end
                else if (!add_ok)
                begin
                    result_next.status = artt_pkg::ST_FULL;
                end
                else
                begin
                    result_next.status     = artt_pkg::ST_OK;
                    result_next.overlapped = ov_reg;
                end
            end
            artt_pkg::MODE_PITCH, artt_pkg::MODE_DEL_ADDR:
            begin
                if (hit)
                begin
                    result_next.status = artt_pkg::ST_OK;
                end
            end
            artt_pkg::MODE_DEL_BASE, artt_pkg::MODE_DEL_BSZ:
            begin
                if (found_reg)
                begin
                    result_next.status = artt_pkg::ST_OK;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        raddr_next = raddr_reg;
        if (cmd.start)
        begin
            raddr_next = '0;
        end
        else if (cmd.scan && raddr_reg != IW'(REGIONS - 1))
        begin
            raddr_next = raddr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.finish)
        begin
            if (we && item_reg.mode == artt_pkg::MODE_ADD)
            begin
                valid_reg[add_slot] <= 1'b1;
            end
            else if ((item_reg.mode == artt_pkg::MODE_DEL_ADDR && hit)
                     || ((item_reg.mode == artt_pkg::MODE_DEL_BASE
                          || item_reg.mode == artt_pkg::MODE_DEL_BSZ) && found_reg))
            begin
                valid_reg[best_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        raddr_reg <= raddr_next;
        if (cmd.start)
        begin
            item_reg    <= in_item;
            cmp_idx_reg <= '0;
            cmp_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
            same_reg    <= 1'b0;
            free_reg    <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else if (cmd.scan)
        begin
            cmp_idx_reg <= raddr_reg;
            cmp_vld_reg <= 1'b1;
            if (cmp_vld_reg)
            begin
                if (item_reg.mode == artt_pkg::MODE_DEL_BASE
                    || item_reg.mode == artt_pkg::MODE_DEL_BSZ)
                begin
                    if (c_base)
                    begin
                        found_reg      <= 1'b1;
                        best_reg       <= cmp_idx_reg;
                        best_start_reg <= rdata.start;
                    end
                end
                else if (c_addr)
                begin
                    found_reg      <= 1'b1;
                    best_reg       <= cmp_idx_reg;
                    best_start_reg <= rdata.start;
                end
                if (!is_valid && !free_reg)
                begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= cmp_idx_reg;
                end
                if (is_valid && rdata.start == item_reg.address)
                begin
                    same_reg     <= 1'b1;
                    same_idx_reg <= cmp_idx_reg;
                end
                if (c_ov)
                begin
                    ov_reg <= 1'b1;
                end
            end
        end
        if (cmd.finish)
        begin
            result_reg <= result_next;
        end
    end

endmodule

// ----- hdl/artt_ctrl.sv -----
// ----------------------------------------------------------------------------
// artt_ctrl
// Sequencer: scan of all entries, optional fetch, result, handshake.
// ----------------------------------------------------------------------------
module artt_ctrl #(
    parameter int REGIONS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output artt_pkg::artt_cmd_t  cmd,
    input  artt_pkg::artt_stat_t stat
);

    localparam int CW = $clog2(REGIONS + 1);

    artt_pkg::artt_state_t state_reg, state_next;
    logic [CW-1:0]         cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= artt_pkg::S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            artt_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    cnt_next   = '0;
                    state_next = artt_pkg::S_SCAN;
                end
            end
            artt_pkg::S_SCAN:
            begin
                // one read issued per cycle, compare on the read data in the next cycle
                cmd.scan = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(REGIONS))
                begin
                    state_next = stat.need_fetch ? artt_pkg::S_FETCH
                                                 : artt_pkg::S_RESULT;
                end
            end
            artt_pkg::S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = artt_pkg::S_RESULT;
            end
            artt_pkg::S_RESULT:
            begin
                cmd.finish = 1'b1;
                state_next = artt_pkg::S_OUT;
            end
            artt_pkg::S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = artt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = artt_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/address_region_translation_table.sv -----
// ----------------------------------------------------------------------------
// address_region_translation_table
// Region table with lookup, add, pitch update and delete operations.
// ----------------------------------------------------------------------------
// Each item is one operation. The block reads every entry of the region
// memory once, one per cycle, to find the matching region, a free slot and
// any overlap, then reads the chosen entry again where the result needs it
// and writes back. Lookup, set pitch and delete by address read the chosen
// entry again in the fetch state before the result; add and the deletes by
// base go from the scan straight to the result. The block returns to idle
// once the result is taken. One item is in work at a time. Entry valid bits
// clear at reset, so no clearing pass.
module address_region_translation_table #(
    parameter int REGIONS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  artt_pkg::artt_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output artt_pkg::artt_out_t out_data
);

    artt_pkg::artt_cmd_t  cmd;
    artt_pkg::artt_stat_t stat;

    artt_ctrl #(
        .REGIONS(REGIONS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    artt_datapath #(
        .REGIONS(REGIONS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .stat   (stat),
        .in_item(in_data),
        .result (out_data)
    );

endmodule
